// ----- sv/thermistor_light_sample_converter_assert.svh -----
// Assertion macros for the thermistor and light sample converter.
`ifndef THERMISTOR_LIGHT_SAMPLE_CONVERTER_ASSERT_SVH
`define THERMISTOR_LIGHT_SAMPLE_CONVERTER_ASSERT_SVH

// Implication in the same cycle.
`define TLSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlsc assertion failed");

// Implication in the next cycle.
`define TLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlsc assertion failed");

`endif

// ----- sv/tlsc_pkg.sv -----
// Constants shared by the thermistor and light sample converter.
package tlsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BETA      = 2'd0;
  localparam logic [1:0] REG_DARK      = 2'd1;
  localparam logic [1:0] REG_FULLSCALE = 2'd2;

  localparam logic [13:0] BETA_RESET      = 14'd3380;
  localparam logic [14:0] DARK_RESET      = 15'd100;
  localparam logic [14:0] FULLSCALE_RESET = 15'd32767;

  // ln 2 in Q32, ln(Rref / Rinf) in Q16
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [21:0] LN_RATIO_Q16 = 22'd742954;
  // 100 * 65536, scales beta to centi-kelvin over a Q16 log
  localparam logic [31:0] BETA_SCALE   = 32'd6553600;
  localparam logic [37:0] ABS_ZERO_CENTI = 38'd27315;
  localparam logic [37:0] TEMP_SAT_QUO   = 38'd2027315;
  localparam logic [21:0] TEMP_LIMIT     = 22'd2000000;

  localparam int LOG_W  = 24;  // log2 in Q20 of a 15 bit count
  localparam int LN_W   = 20;  // ln in Q16
  localparam int DIV_NW = 38;  // divider numerator / quotient width
  localparam int DIV_DW = 24;  // divider divisor width

endpackage

// ----- sv/thermistor_light_sample_converter.sv -----
// Top level of the thermistor and light sample converter.
//
// Each accepted item carries a channel number and a signed converter count.
// Channels below NUM_CHANNELS overwrite their latest count and mark the
// channel seen; other channels only request a snapshot. Every item produces
// one result item: the five latest counts (zero for channels that do not
// exist), a beta-equation temperature in signed hundredths of a degree
// (zero when the thermistor or reference count is not positive, saturated
// at +2000000), a logarithmic light level 0..100 percent clamped at the
// dark and full-scale counts, and a flag set once all channels were seen.
// Five base-2 logarithms run first on the one shared 32x32 multiplier, each
// a normalize step and twenty squarings, with a scale to natural log for
// the two temperature counts. Then come a setup state, a multiply state and
// a 38-step restoring division for the temperature (the multiply and
// division are skipped when the temperature reads zero), a setup state and
// a 38-step division for the light level (skipped when the level is
// clamped), and a state that loads the output register. The input stays
// stalled while an item is in work; a finished result waits in the output
// register so the next item can be taken meanwhile. Configuration writes
// are always ready and must only be issued while the block is idle.
module thermistor_light_sample_converter #(
  parameter int NUM_CHANNELS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  // input item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         channel_i,
  input  logic signed [15:0] sample_i,
  // result item channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] reference_count_o,
  output logic signed [15:0] thermistor_count_o,
  output logic signed [15:0] light_count_o,
  output logic signed [15:0] aux0_count_o,
  output logic signed [15:0] aux1_count_o,
  output logic signed [21:0] temperature_centi_o,
  output logic [6:0]         light_pct_o,
  output logic               all_seen_o
);

  `include "thermistor_light_sample_converter_assert.svh"

  localparam int LW = tlsc_pkg::LOG_W;
  localparam int NW = tlsc_pkg::DIV_NW;
  localparam int DW = tlsc_pkg::DIV_DW;
  localparam int NL = tlsc_pkg::LN_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NORM   = 4'd1;
  localparam logic [3:0] ST_SQR    = 4'd2;
  localparam logic [3:0] ST_LN     = 4'd3;
  localparam logic [3:0] ST_TSETUP = 4'd4;
  localparam logic [3:0] ST_TMUL   = 4'd5;
  localparam logic [3:0] ST_TDIV   = 4'd6;
  localparam logic [3:0] ST_LSETUP = 4'd7;
  localparam logic [3:0] ST_LDIV   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // log operand slots
  localparam logic [2:0] OP_THERM = 3'd0;
  localparam logic [2:0] OP_REF   = 3'd1;
  localparam logic [2:0] OP_LIGHT = 3'd2;
  localparam logic [2:0] OP_DARK  = 3'd3;
  localparam logic [2:0] OP_FULL  = 3'd4;

  logic [3:0] state_q, state_d;

  // configuration
  logic [13:0] beta_q;
  logic [14:0] dark_q, full_q;

  // channel store and seen mask
  logic signed [15:0]      store_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] seen_q;
  logic signed [15:0]      cnt [5];

  // log unit
  logic [2:0]    op_q, op_d;
  logic [4:0]    bit_q, bit_d;
  logic [30:0]   m_q, m_d;
  logic [LW-1:0] res_q, res_d;
  logic [NL-1:0] ln_t_q, ln_t_d, ln_r_q, ln_r_d;
  logic [LW-1:0] lg_c_q, lg_c_d, lg_d_q, lg_d_d, lg_f_q, lg_f_d;

  // divider
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]    dcnt_q, dcnt_d;

  // results
  logic [21:0] temp_q, temp_d;
  logic [6:0]  pct_q, pct_d;
  logic        out_valid_q, out_valid_d;

  logic signed [15:0] o_cnt_q [5];
  logic signed [21:0] o_temp_q;
  logic [6:0]         o_pct_q;
  logic               o_seen_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic        in_acc, out_free;
  logic [14:0] op_raw, op_n;
  logic [3:0]  e_pos;
  logic [30:0] m_norm;
  logic [31:0] sq;
  logic [63:0] lnp;
  logic signed [21:0] l_val;
  logic        temp_ok;
  logic signed [LW:0] n_val, d_val;
  logic [LW-1:0] n_pos;
  logic [31:0]   n_x100;
  logic [DW:0]   trial;
  logic          light_lo, light_hi;
  logic [NW-1:0] quo_sh;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // counts visible in the snapshot, zero where the channel does not exist
  for (genvar g = 0; g < 5; g++) begin : g_cnt
    if (g < NUM_CHANNELS) begin : g_have
      assign cnt[g] = store_q[g];
    end else begin : g_none
      assign cnt[g] = 16'sd0;
    end
  end

  // operand for the log unit; zero and negatives go in as one
  always_comb begin
    case (op_q)
      OP_THERM: op_raw = (cnt[1] > 16'sd0) ? cnt[1][14:0] : 15'd1;
      OP_REF:   op_raw = (cnt[0] > 16'sd0) ? cnt[0][14:0] : 15'd1;
      OP_LIGHT: op_raw = (cnt[2] > 16'sd0) ? cnt[2][14:0] : 15'd1;
      OP_DARK:  op_raw = dark_q;
      default:  op_raw = full_q;
    endcase
    op_n = (op_raw == 15'd0) ? 15'd1 : op_raw;
  end

  // top set bit and mantissa in Q30
  always_comb begin
    e_pos = 4'd0;
    for (int b = 0; b < 15; b++) begin
      if (op_n[b]) e_pos = 4'(b);
    end
    m_norm = 31'(op_n) << (5'd30 - {1'b0, e_pos});
  end

  always_comb begin
    mul_a = {1'b0, m_q};
    mul_b = {1'b0, m_q};
    case (state_q)
      ST_LN: begin
        mul_a = 32'(res_q);
        mul_b = tlsc_pkg::LN2_Q32;
      end
      ST_TMUL: begin
        mul_a = 32'(beta_q);
        mul_b = tlsc_pkg::BETA_SCALE;
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sq   = prod[61:30];
  assign lnp  = prod + 64'h8_0000_0000;

  // temperature divisor: ln(therm) - ln(ref) + ln(Rref/Rinf)
  assign l_val   = $signed({2'b00, ln_t_q}) - $signed({2'b00, ln_r_q})
                   + $signed(tlsc_pkg::LN_RATIO_Q16);
  assign temp_ok = (cnt[1] > 16'sd0) && (cnt[0] > 16'sd0) && (l_val > 22'sd0);

  // light terms
  assign light_lo = (cnt[2] <= $signed({1'b0, dark_q}));
  assign light_hi = (cnt[2] >= $signed({1'b0, full_q}));
  assign n_val    = $signed({1'b0, lg_c_q}) - $signed({1'b0, lg_d_q});
  assign d_val    = $signed({1'b0, lg_f_q}) - $signed({1'b0, lg_d_q});
  assign n_pos    = n_val[LW] ? '0 : n_val[LW-1:0];
  assign n_x100   = (32'(n_pos) << 6) + (32'(n_pos) << 5) + (32'(n_pos) << 2);

  // one restoring division step
  assign trial  = {rem_q, quo_q[NW-1]};
  assign quo_sh = {quo_q[NW-2:0], 1'b0};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    bit_d       = bit_q;
    m_d         = m_q;
    res_d       = res_q;
    ln_t_d      = ln_t_q;
    ln_r_d      = ln_r_q;
    lg_c_d      = lg_c_q;
    lg_d_d      = lg_d_q;
    lg_f_d      = lg_f_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    dcnt_d      = dcnt_q;
    temp_d      = temp_q;
    pct_d       = pct_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (state_q != ST_IDLE && state_q != ST_DONE &&
        (state_q == ST_TDIV || state_q == ST_LDIV)) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        quo_d = quo_sh | NW'(1);
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = quo_sh;
      end
      dcnt_d = dcnt_q - 6'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = OP_THERM;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        m_d     = m_norm;
        res_d   = {e_pos, 20'd0};
        bit_d   = 5'd19;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        if (sq[31]) begin
          m_d          = sq[31:1];
          res_d[bit_q] = 1'b1;
        end else begin
          m_d = sq[30:0];
        end
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          if (op_q == OP_THERM || op_q == OP_REF) begin
            state_d = ST_LN;
          end else begin
            case (op_q)
              OP_LIGHT: lg_c_d = res_d;
              OP_DARK:  lg_d_d = res_d;
              default:  lg_f_d = res_d;
            endcase
            op_d    = op_q + 3'd1;
            state_d = (op_q == OP_FULL) ? ST_TSETUP : ST_NORM;
          end
        end
      end
      ST_LN: begin
        if (op_q == OP_THERM) ln_t_d = lnp[55:36];
        else                  ln_r_d = lnp[55:36];
        op_d    = op_q + 3'd1;
        state_d = ST_NORM;
      end
      ST_TSETUP: begin
        if (temp_ok) begin
          state_d = ST_TMUL;
        end else begin
          temp_d  = '0;
          state_d = ST_LSETUP;
        end
      end
      ST_TMUL: begin
        // numerator beta * 100 * 65536 + l / 2
        quo_d   = NW'(prod[36:0]) + NW'(l_val[20:1]);
        rem_d   = '0;
        dvs_d   = DW'(l_val[20:0]);
        dcnt_d  = 6'(NW - 1);
        state_d = ST_TDIV;
      end
      ST_TDIV: begin
        if (dcnt_q == 6'd0) begin
          if (quo_d > tlsc_pkg::TEMP_SAT_QUO) temp_d = tlsc_pkg::TEMP_LIMIT;
          else temp_d = 22'(quo_d - tlsc_pkg::ABS_ZERO_CENTI);
          state_d = ST_LSETUP;
        end
      end
      ST_LSETUP: begin
        if (light_lo) begin
          pct_d   = 7'd0;
          state_d = ST_DONE;
        end else if (light_hi || d_val[LW] || d_val == '0) begin
          pct_d   = 7'd100;
          state_d = ST_DONE;
        end else begin
          quo_d   = NW'(n_x100) + NW'(d_val[LW-1:1]);
          rem_d   = '0;
          dvs_d   = DW'(d_val[LW-1:0]);
          dcnt_d  = 6'(NW - 1);
          state_d = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (dcnt_q == 6'd0) begin
          pct_d   = (quo_d > NW'(100)) ? 7'd100 : quo_d[6:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      beta_q      <= tlsc_pkg::BETA_RESET;
      dark_q      <= tlsc_pkg::DARK_RESET;
      full_q      <= tlsc_pkg::FULLSCALE_RESET;
      seen_q      <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) store_q[c] <= 16'sd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tlsc_pkg::REG_BETA:      beta_q <= cfg_data_i[13:0];
          tlsc_pkg::REG_DARK:      dark_q <= cfg_data_i;
          tlsc_pkg::REG_FULLSCALE: full_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (channel_i == 4'(c)) begin
            store_q[c] <= sample_i;
            seen_q[c]  <= 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    bit_q  <= bit_d;
    m_q    <= m_d;
    res_q  <= res_d;
    ln_t_q <= ln_t_d;
    ln_r_q <= ln_r_d;
    lg_c_q <= lg_c_d;
    lg_d_q <= lg_d_d;
    lg_f_q <= lg_f_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    dcnt_q <= dcnt_d;
    temp_q <= temp_d;
    pct_q  <= pct_d;
    if (state_q == ST_DONE && out_free) begin
      for (int c = 0; c < 5; c++) o_cnt_q[c] <= cnt[c];
      o_temp_q <= temp_q;
      o_pct_q  <= pct_q;
      o_seen_q <= &seen_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign reference_count_o   = o_cnt_q[0];
  assign thermistor_count_o  = o_cnt_q[1];
  assign light_count_o       = o_cnt_q[2];
  assign aux0_count_o        = o_cnt_q[3];
  assign aux1_count_o        = o_cnt_q[4];
  assign temperature_centi_o = o_temp_q;
  assign light_pct_o         = o_pct_q;
  assign all_seen_o          = o_seen_q;

  // an accepted item keeps the sequencer busy
  `TLSC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, state_q == ST_NORM)
  // light level never exceeds full scale
  `TLSC_ASSERT_NOW(a_pct_range, clk_i, rst_ni, out_valid_o, light_pct_o <= 7'd100)
  // temperature stays inside the saturation limits
  `TLSC_ASSERT_NOW(a_temp_range, clk_i, rst_ni, out_valid_o,
    (temperature_centi_o <= 22'sd2000000) && (temperature_centi_o >= -22'sd2000000))

endmodule

// ----- tb/sv/tb_thermistor_light_sample_converter.sv -----
// Self-checking testbench for the thermistor and light sample converter.
module tb_thermistor_light_sample_converter;

  typedef struct packed {
    logic signed [15:0] ref_c;
    logic signed [15:0] therm_c;
    logic signed [15:0] light_c;
    logic signed [15:0] aux0_c;
    logic signed [15:0] aux1_c;
    logic signed [21:0] temp;
    logic [6:0]         pct;
    logic               seen;
  } snapshot_t;

  // which fields of a directed row are typed in rather than predicted
  localparam logic [2:0] FIX_NONE = 3'b000;
  localparam logic [2:0] FIX_TEMP = 3'b001;
  localparam logic [2:0] FIX_PCT  = 3'b010;
  localparam logic [2:0] FIX_SEEN = 3'b100;

  typedef struct {
    logic [3:0]         ch;
    logic signed [15:0] smp;
    logic [2:0]         fix;
    logic signed [21:0] temp;
    logic [6:0]         pct;
    logic               seen;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = tlsc_pkg::REG_BETA;
  logic [14:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         channel_i = '0;
  logic signed [15:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] reference_count_o, thermistor_count_o, light_count_o;
  logic signed [15:0] aux0_count_o, aux1_count_o;
  logic signed [21:0] temperature_centi_o;
  logic [6:0]         light_pct_o;
  logic               all_seen_o;

  thermistor_light_sample_converter dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state: latest counts, seen mask and register copies
  logic signed [15:0] latest_cnt [5];
  logic [4:0]         seen_bits;
  logic [13:0]        beta_reg;
  logic [14:0]        dark_reg;
  logic [14:0]        full_reg;

  snapshot_t pending_snaps [$];
  int mismatches;
  int results_seen;
  int items_sent;
  int phases_run;
  bit in_bursty;
  bit out_bursty;

  // log2 in Q20 by repeated squaring of a Q30 mantissa
  function automatic longint unsigned log2_fix(int unsigned n);
    int unsigned        e;
    longint unsigned    m;
    longint unsigned    acc;
    if (n == 0) n = 1;
    e = 0;
    while (e < 31 && (n >> (e + 1)) != 0) e++;
    if (e <= 30) m = longint'(n) << (30 - e);
    else m = longint'(n) >> (e - 30);
    acc = longint'(e) << 20;
    for (int i = 19; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic longint ln_fix(int unsigned n);
    longint unsigned p;
    p = log2_fix(n) * longint'(tlsc_pkg::LN2_Q32) + (64'd1 << 35);
    return longint'(p >> 36);
  endfunction

  function automatic logic signed [21:0] beta_temp(int therm, int refc);
    longint l;
    longint num;
    longint q;
    if (therm <= 0 || refc <= 0) return '0;
    l = ln_fix(therm) - ln_fix(refc) + longint'(tlsc_pkg::LN_RATIO_Q16);
    if (l <= 0) return '0;
    num = longint'(beta_reg) * longint'(tlsc_pkg::BETA_SCALE);
    q = (num + l / 2) / l - longint'(tlsc_pkg::ABS_ZERO_CENTI);
    if (q > longint'(tlsc_pkg::TEMP_LIMIT)) q = longint'(tlsc_pkg::TEMP_LIMIT);
    if (q < -longint'(tlsc_pkg::TEMP_LIMIT)) q = -longint'(tlsc_pkg::TEMP_LIMIT);
    return q[21:0];
  endfunction

  function automatic logic [6:0] light_level(int c);
    int unsigned dk;
    longint n;
    longint d;
    longint p;
    if (c <= int'(dark_reg)) return 7'd0;
    if (c >= int'(full_reg)) return 7'd100;
    dk = (dark_reg == '0) ? 32'd1 : 32'(dark_reg);
    n = longint'(log2_fix(c)) - longint'(log2_fix(dk));
    d = longint'(log2_fix(32'(full_reg))) - longint'(log2_fix(dk));
    if (d <= 0) return 7'd100;
    if (n < 0) n = 0;
    p = (100 * n + d / 2) / d;
    if (p > 100) p = 100;
    return p[6:0];
  endfunction

  // advance the predictor by one item and return its snapshot
  function automatic snapshot_t next_snapshot(logic [3:0] ch, logic signed [15:0] smp);
    snapshot_t s;
    if (ch < 5) begin
      latest_cnt[ch[2:0]] = smp;
      seen_bits[ch[2:0]] = 1'b1;
    end
    s.ref_c   = latest_cnt[0];
    s.therm_c = latest_cnt[1];
    s.light_c = latest_cnt[2];
    s.aux0_c  = latest_cnt[3];
    s.aux1_c  = latest_cnt[4];
    s.temp    = beta_temp(latest_cnt[1], latest_cnt[0]);
    s.pct     = light_level(latest_cnt[2]);
    s.seen    = &seen_bits;
    return s;
  endfunction

  function automatic int draw_wait(bit bursty);
    return bursty ? $urandom_range(0, 17) : 0;
  endfunction

  // send one item and, once it is taken, queue its expected snapshot
  task automatic send_item(logic [3:0] ch, logic signed [15:0] smp, logic [2:0] fix,
                           logic signed [21:0] t, logic [6:0] p, logic sn);
    int        gap;
    snapshot_t s;
    if ($urandom_range(0, 39) == 0) in_bursty = !in_bursty;
    gap = draw_wait(in_bursty);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    s = next_snapshot(ch, smp);
    if (fix & FIX_TEMP) s.temp = t;
    if (fix & FIX_PCT) s.pct = p;
    if (fix & FIX_SEEN) s.seen = sn;
    pending_snaps.push_back(s);
    items_sent++;
  endtask

  // hold until every result is back, then let the block settle
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_snaps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      tlsc_pkg::REG_BETA:      beta_reg = val[13:0];
      tlsc_pkg::REG_DARK:      dark_reg = val;
      tlsc_pkg::REG_FULLSCALE: full_reg = val;
      default: begin
      end
    endcase
  endtask

  // random item: mostly live channels with counts that reach the math
  task automatic send_random;
    int                 r;
    logic [3:0]         ch;
    logic signed [15:0] smp;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      ch  = 4'($urandom_range(5, 15));
      smp = 16'($urandom);
    end else begin
      ch = 4'($urandom_range(0, 4));
      if (r < 25) smp = 16'($urandom);
      else if (ch == 2 && dark_reg < full_reg && r < 80)
        smp = 16'($urandom_range(int'(dark_reg), int'(full_reg)));
      else if (r < 35) smp = 16'($urandom_range(1, 64));
      else smp = 16'($urandom_range(1, 32767));
    end
    send_item(ch, smp, FIX_NONE, '0, '0, 1'b0);
  endtask

  task automatic check_field(string name, logic signed [63:0] exp_v,
                             logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // score every result taken at this edge against the oldest expectation
  always @(posedge clk_i) begin
    snapshot_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_snaps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item arrived with nothing expected");
      end else begin
        e = pending_snaps.pop_front();
        check_field("reference_count", e.ref_c, reference_count_o);
        check_field("thermistor_count", e.therm_c, thermistor_count_o);
        check_field("light_count", e.light_c, light_count_o);
        check_field("aux0_count", e.aux0_c, aux0_count_o);
        check_field("aux1_count", e.aux1_c, aux1_count_o);
        check_field("temperature_centi", e.temp, temperature_centi_o);
        check_field("light_pct", e.pct, light_pct_o);
        check_field("all_seen", e.seen, all_seen_o);
      end
    end
  end

  // output back-pressure: a random stall ahead of each result
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) out_bursty = !out_bursty;
      n = draw_wait(out_bursty);
      out_stall_i <= (n > 0);
      if (n > 0) begin
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  initial begin
    #30000000;
    $display("timeout with %0d results still expected", pending_snaps.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  row_t directed [] = '{
    '{4'd15, 16'sd0,      FIX_TEMP | FIX_PCT | FIX_SEEN, 22'sd0, 7'd0, 1'b0},
    '{4'd0,  -16'sd32768, FIX_TEMP | FIX_PCT | FIX_SEEN, 22'sd0, 7'd0, 1'b0},
    '{4'd1,  16'sd32767,  FIX_TEMP, 22'sd0, 7'd0, 1'b0},
    '{4'd0,  16'sd32767,  FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd1,  16'sd1,      FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd0,  16'sd1,      FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd1,  -16'sd1,     FIX_TEMP, 22'sd0, 7'd0, 1'b0},
    '{4'd1,  16'sd0,      FIX_TEMP, 22'sd0, 7'd0, 1'b0},
    '{4'd1,  16'sd10000,  FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd0,  16'sd10000,  FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd2,  16'sd32767,  FIX_PCT,  22'sd0, 7'd100, 1'b0},
    '{4'd2,  -16'sd32768, FIX_PCT,  22'sd0, 7'd0, 1'b0},
    '{4'd2,  16'sd100,    FIX_PCT,  22'sd0, 7'd0, 1'b0},
    '{4'd2,  16'sd101,    FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd2,  16'sd32766,  FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd3,  -16'sd32768, FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd3,  16'sd32767,  FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd4,  16'sd0,      FIX_SEEN, 22'sd0, 7'd0, 1'b1},
    '{4'd4,  -16'sd1,     FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd5,  16'sd1234,   FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd8,  -16'sd5,     FIX_NONE, 22'sd0, 7'd0, 1'b0},
    '{4'd2,  16'sd1000,   FIX_NONE, 22'sd0, 7'd0, 1'b0}
  };

  // register settings per phase: beta (raw write data), dark, full scale;
  // the third phase writes a beta with only bit 14 set, which reads as zero
  logic [14:0] phase_cfg [7][3] = '{
    '{15'd16383, 15'd0,     15'd1},
    '{15'd1,     15'd32767, 15'd32767},
    '{15'h4000,  15'd500,   15'd200},
    '{15'd3380,  15'd0,     15'd32767},
    '{15'd16383, 15'd32767, 15'd1},
    '{15'd4250,  15'd40,    15'd20000},
    '{15'd2000,  15'd3000,  15'd9000}
  };

  initial begin
    foreach (latest_cnt[i]) latest_cnt[i] = '0;
    seen_bits = '0;
    beta_reg  = tlsc_pkg::BETA_RESET;
    dark_reg  = tlsc_pkg::DARK_RESET;
    full_reg  = tlsc_pkg::FULLSCALE_RESET;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    phases_run = 1;
    in_bursty = 1'b1;
    out_bursty = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset register values
    foreach (directed[i])
      send_item(directed[i].ch, directed[i].smp, directed[i].fix,
                directed[i].temp, directed[i].pct, directed[i].seen);
    repeat (100) send_random();

    // one phase per register setting, the last with random values
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 7) begin
        write_reg(tlsc_pkg::REG_BETA, phase_cfg[ph][0]);
        write_reg(tlsc_pkg::REG_DARK, phase_cfg[ph][1]);
        write_reg(tlsc_pkg::REG_FULLSCALE, phase_cfg[ph][2]);
      end else begin
        write_reg(tlsc_pkg::REG_BETA, 15'($urandom_range(1, 16383)));
        write_reg(tlsc_pkg::REG_DARK, 15'($urandom_range(0, 2000)));
        write_reg(tlsc_pkg::REG_FULLSCALE, 15'($urandom_range(4000, 32767)));
      end
      phases_run++;
      repeat (103) send_random();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d sample items sent over %0d register settings, %0d results scored",
             items_sent, phases_run, results_seen);
    $display("%0d field mismatches, %0d results never arrived",
             mismatches, pending_snaps.size());
    if (mismatches == 0 && pending_snaps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
